/* src/tstc_pkg.sv */
// Shared types and constants of the threshold spanning-tree cost block.
package tstc_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam int NODE_W = 11;
    localparam int WGT_W  = 32;
    localparam int COST_W = 44;
    localparam int EDGE_W = 2 * NODE_W + WGT_W;

    // configuration register indexes
    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    // one edge word as it travels from the front to the back
    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [WGT_W-1:0]  weight;
        logic              last_edge;
    } tstc_word_t;

endpackage

/* src/tstc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tstc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/tstc_front.sv */
// Front end: accepts edge words and holds them in a two-entry queue.
module tstc_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tstc_pkg::NODE_W-1:0] s_node_a,
    input  logic [tstc_pkg::NODE_W-1:0] s_node_b,
    input  logic [tstc_pkg::WGT_W-1:0]  s_weight,
    input  logic                       s_last_edge,
    output logic                       q_valid,
    input  logic                       q_ready,
    output tstc_pkg::tstc_word_t       q_word
);
    import tstc_pkg::*;

    tstc_word_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_word  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{node_a: s_node_a, node_b: s_node_b,
                                      weight: s_weight, last_edge: s_last_edge};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg != 2'd3)
        else $error("edge queue overfilled");

endmodule

/* src/tstc_back.sv */
// Back end: edge store, level-by-level Kruskal with union-find, result register.
module tstc_back #(
    parameter int MAX_NODES = tstc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tstc_pkg::DEF_MAX_EDGES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  tstc_pkg::tstc_word_t         q_word,
    input  logic [tstc_pkg::WGT_W-1:0]   threshold,
    input  logic [tstc_pkg::NODE_W-1:0]  node_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tstc_pkg::COST_W-1:0]  m_total_cost
);
    import tstc_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC = $clog2(MAX_EDGES + 1);
    localparam int CW = (NW + 1 > NODE_W) ? NW + 1 : NODE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_EADDR = 4'd3;
    localparam logic [3:0] S_EDATA = 4'd4;
    localparam logic [3:0] S_FADDR = 4'd5;
    localparam logic [3:0] S_FDATA = 4'd6;
    localparam logic [3:0] S_UNION = 4'd7;
    localparam logic [3:0] S_END   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [EC-1:0]     cnt_reg, cnt_next;
    logic [EC-1:0]     idx_reg, idx_next;
    logic [NW-1:0]     init_reg, init_next;
    logic              proc_reg, proc_next;   // 1: union pass, 0: next-level search
    logic              first_reg, first_next; // level-zero pass, also gathers the gap
    logic [WGT_W-1:0]  lvl_reg, lvl_next;
    logic [WGT_W-1:0]  nxt_reg, nxt_next;
    logic              found_reg, found_next;
    logic [NW:0]       comps_reg, comps_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [WGT_W-1:0]  gap_reg, gap_next;
    logic [NW-1:0]     ib_reg, ib_next;
    logic [NW-1:0]     x_reg, x_next, ra_reg, ra_next;
    logic              side_reg, side_next;
    logic [WGT_W-1:0]  ex_reg, ex_next;
    logic [COST_W-1:0] res_reg, res_next;
    logic              mv_reg, mv_next;
    logic [COST_W-1:0] mc_reg, mc_next;

    // edge store
    logic              e_we;
    logic [EW-1:0]     e_waddr, e_raddr;
    logic [EDGE_W-1:0] e_wdata, e_rdata;
    // parent links
    logic              p_we;
    logic [NW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;

    tstc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    tstc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent_ram (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // clamped node count
    logic [CW-1:0]     nc_ext, n_cl;
    logic [NW:0]       n_val;
    // decoded edge
    logic [NODE_W-1:0] ea, eb;
    logic [WGT_W-1:0]  ew, ex_c, gap_c;
    logic              e_ok;
    logic              pop;

    always_comb begin
        nc_ext = CW'(node_count);
        if (nc_ext == '0) begin
            n_cl = CW'(1);
        end else if (nc_ext > CW'(MAX_NODES)) begin
            n_cl = CW'(MAX_NODES);
        end else begin
            n_cl = nc_ext;
        end
        n_val = (NW + 1)'(n_cl);

        ea    = e_rdata[EDGE_W-1 -: NODE_W];
        eb    = e_rdata[WGT_W +: NODE_W];
        ew    = e_rdata[WGT_W-1:0];
        e_ok  = (ea != '0) && (CW'(ea) <= n_cl) && (eb != '0) && (CW'(eb) <= n_cl);
        ex_c  = (ew > threshold) ? ew - threshold : '0;
        gap_c = (ew >= threshold) ? ew - threshold : threshold - ew;
    end

    assign q_ready      = (state_reg == S_IDLE);
    assign pop          = q_valid && q_ready;
    assign m_valid      = mv_reg;
    assign m_total_cost = mc_reg;

    assign e_we    = pop && (cnt_reg < EC'(MAX_EDGES));
    assign e_waddr = cnt_reg[EW-1:0];
    assign e_wdata = {q_word.node_a, q_word.node_b, q_word.weight};
    assign e_raddr = idx_reg[EW-1:0];
    assign p_raddr = x_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        init_next  = init_reg;
        proc_next  = proc_reg;
        first_next = first_reg;
        lvl_next   = lvl_reg;
        nxt_next   = nxt_reg;
        found_next = found_reg;
        comps_next = comps_reg;
        cost_next  = cost_reg;
        gap_next   = gap_reg;
        ib_next    = ib_reg;
        x_next     = x_reg;
        ra_next    = ra_reg;
        side_next  = side_reg;
        ex_next    = ex_reg;
        res_next   = res_reg;
        mv_next    = (mv_reg && m_ready) ? 1'b0 : mv_reg;
        mc_next    = mc_reg;
        p_we       = 1'b0;
        p_waddr    = init_reg;
        p_wdata    = init_reg;

        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    if (e_we) begin
                        cnt_next = cnt_reg + EC'(1);
                    end
                    if (q_word.last_edge) begin
                        init_next  = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                p_we = 1'b1;
                if ((NW + 1)'(init_reg) == n_val - (NW + 1)'(1)) begin
                    comps_next = n_val;
                    cost_next  = '0;
                    lvl_next   = '0;
                    proc_next  = 1'b1;
                    first_next = 1'b1;
                    state_next = S_START;
                end else begin
                    init_next = init_reg + NW'(1);
                end
            end
            S_START: begin
                idx_next   = '0;
                state_next = (cnt_reg == '0) ? S_END : S_EADDR;
            end
            S_EADDR: begin
                state_next = S_EDATA;
            end
            S_EDATA: begin
                if (first_reg && e_ok && gap_c < gap_reg) begin
                    gap_next = gap_c;
                end
                if (proc_reg && e_ok && ex_c == lvl_reg) begin
                    ib_next    = NW'(eb - NODE_W'(1));
                    x_next     = NW'(ea - NODE_W'(1));
                    ex_next    = ex_c;
                    side_next  = 1'b0;
                    state_next = S_FADDR;
                end else begin
                    if (!proc_reg && e_ok && ex_c > lvl_reg && (!found_reg || ex_c < nxt_reg))
                    begin
                        found_next = 1'b1;
                        nxt_next   = ex_c;
                    end
                    if (idx_reg == cnt_reg - EC'(1)) begin
                        state_next = S_END;
                    end else begin
                        idx_next   = idx_reg + EC'(1);
                        state_next = S_EADDR;
                    end
                end
            end
            S_FADDR: begin
                state_next = S_FDATA;
            end
            S_FDATA: begin
                if (p_rdata == x_reg) begin
                    if (!side_reg) begin
                        ra_next    = x_reg;
                        x_next     = ib_reg;
                        side_next  = 1'b1;
                        state_next = S_FADDR;
                    end else begin
                        state_next = S_UNION;
                    end
                end else begin
                    x_next     = p_rdata;
                    state_next = S_FADDR;
                end
            end
            S_UNION: begin
                if (ra_reg != x_reg) begin
                    p_we       = 1'b1;
                    p_waddr    = ra_reg;
                    p_wdata    = x_reg;
                    comps_next = comps_reg - (NW + 1)'(1);
                    cost_next  = cost_reg + COST_W'(ex_reg);
                end
                if (idx_reg == cnt_reg - EC'(1)) begin
                    state_next = S_END;
                end else begin
                    idx_next   = idx_reg + EC'(1);
                    state_next = S_EADDR;
                end
            end
            S_END: begin
                if (proc_reg) begin
                    if (first_reg && comps_reg == (NW + 1)'(1)) begin
                        res_next   = COST_W'(gap_reg);
                        state_next = S_OUT;
                    end else begin
                        first_next = 1'b0;
                        proc_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = S_START;
                    end
                end else if (!found_reg) begin
                    res_next   = cost_reg;
                    state_next = S_OUT;
                end else begin
                    lvl_next   = nxt_reg;
                    proc_next  = 1'b1;
                    state_next = S_START;
                end
            end
            S_OUT: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    mc_next    = res_reg;
                    cnt_next   = '0;
                    gap_next   = '1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            gap_reg   <= '1;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            gap_reg   <= gap_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        init_reg  <= init_next;
        proc_reg  <= proc_next;
        first_reg <= first_next;
        lvl_reg   <= lvl_next;
        nxt_reg   <= nxt_next;
        found_reg <= found_next;
        comps_reg <= comps_next;
        cost_reg  <= cost_next;
        ib_reg    <= ib_next;
        x_reg     <= x_next;
        ra_reg    <= ra_next;
        side_reg  <= side_next;
        ex_reg    <= ex_next;
        res_reg   <= res_next;
        mc_reg    <= mc_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= EC'(MAX_EDGES))
        else $error("edge count beyond store depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UNION) |-> (comps_reg != '0))
        else $error("component count ran out during union");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UNION && ra_reg != x_reg) |=> (comps_reg == $past(comps_reg) - 1'b1))
        else $error("union did not merge two components");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !mv_reg) |=> (mv_reg && state_reg == S_IDLE))
        else $error("result not loaded into output register");

endmodule

/* src/threshold_spanning_tree_cost.sv */
// Top level of the threshold spanning-tree cost block: config registers, front, back.
// Edges: one word per cycle via a two-entry queue while the back end is idle; each is
// stored while the store has room. Last edge: the parent table is reset for the clamped
// node_count; in a union pass an edge of the level finds both roots and joins them.
// Zero-excess union pass first, then, unless it joined all nodes, search + union per
// further level and a final search; m_valid rises via S_OUT once the output is free.
// Reset (sync, active low): queue, edge count, result empty; threshold 0, node_count 1.
module threshold_spanning_tree_cost #(
    parameter int MAX_NODES = tstc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = tstc_pkg::DEF_MAX_EDGES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [tstc_pkg::WGT_W-1:0]   cfg_data,
    // edge words in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tstc_pkg::NODE_W-1:0]  s_node_a,
    input  logic [tstc_pkg::NODE_W-1:0]  s_node_b,
    input  logic [tstc_pkg::WGT_W-1:0]   s_weight,
    input  logic                         s_last_edge,
    // result word out
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tstc_pkg::COST_W-1:0]  m_total_cost
);
    import tstc_pkg::*;

    logic [WGT_W-1:0]  threshold_reg;
    logic [NODE_W-1:0] node_count_reg;

    // the user must let these registers change only while the block is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= '0;
            node_count_reg <= NODE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_THRESHOLD:  threshold_reg  <= cfg_data;
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NODE_W-1:0];
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    logic       q_valid, q_ready;
    tstc_word_t q_word;

    // front: takes words and decouples the input side from the solver
    tstc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_node_a(s_node_a), .s_node_b(s_node_b),
        .s_weight(s_weight), .s_last_edge(s_last_edge),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    // back: stores edges, runs the spanning-tree solver, holds the result word
    tstc_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .threshold(threshold_reg), .node_count(node_count_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_total_cost(m_total_cost)
    );

endmodule
